### design/k2id_pkg.sv
// Shared types and constants for the key to sequential id map.
package k2id_pkg;

    localparam int KEY_W   = 32;
    localparam int ID_W    = 16;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_ZERO     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_PROBE
    } t_bstate;

    // One table slot: key zero marks an empty slot.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_slot_word;

endpackage

### design/k2id_ram.sv
// Generic simple dual-port RAM with registered read.
module k2id_ram #(
    parameter int W     = 48,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/k2id_fifo.sv
// Two-entry queue between the hashing front end and the probe engine.
module k2id_fifo #(
    parameter int W = 41
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr_valid,
    output logic         o_wr_ready,
    input  logic [W-1:0] i_wr_data,
    output logic         o_rd_valid,
    output logic [W-1:0] o_rd_data,
    input  logic         i_rd_pop
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_push;
    logic         w_pop;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = i_rd_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

### design/k2id_front.sv
// Front end: accepts keys, flags zero keys and computes the home slot.
module k2id_front #(
    parameter int TABLE_SIZE = 256,
    localparam int IDX_W     = $clog2(TABLE_SIZE),
    localparam int FW        = 1 + k2id_pkg::KEY_W + IDX_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_enable,
    input  logic                      i_valid,
    input  logic [k2id_pkg::KEY_W-1:0] i_key,
    output logic                      o_ready,
    output logic                      o_push_valid,
    output logic [FW-1:0]             o_push_data,
    input  logic                      i_push_ready
);
    import k2id_pkg::*;

    localparam bit  IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    // key / N = (key * RECIP) >> RSH, exact for every 32-bit key
    localparam int  RSH     = KEY_W + IDX_W;
    localparam int  RECIP_W = KEY_W + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RSH) / TABLE_SIZE) + 64'd1);
    localparam logic [KEY_W-1:0]   N_K   = KEY_W'(TABLE_SIZE);

    logic             r_busy;
    logic             r_hold;
    logic             r_zero;
    logic             r_phase;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_quo;
    logic [IDX_W-1:0] r_rem;
    logic [2*KEY_W:0] w_prod;
    logic [KEY_W-1:0] w_rem;
    logic             w_acc;
    logic             w_push;

    assign o_ready      = i_enable && !r_busy && (!r_hold || i_push_ready);
    assign w_acc        = i_valid && o_ready;
    assign o_push_valid = r_hold;
    assign w_push       = r_hold && i_push_ready;
    assign o_push_data  = {r_zero, r_key, r_rem};

    // Remainder in two steps: reciprocal multiply, then multiply-subtract.
    assign w_prod = {{(KEY_W + 1){1'b0}}, r_key} * {{KEY_W{1'b0}}, RECIP};
    assign w_rem  = r_key - (r_quo * N_K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_hold <= 1'b0;
        end else begin
            if (w_acc) begin
                if (IS_POW2 || (i_key == '0)) begin
                    r_hold <= 1'b1;
                end else begin
                    r_hold <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_phase) begin
                r_busy <= 1'b0;
                r_hold <= 1'b1;
            end else if (w_push) begin
                r_hold <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_key   <= i_key;
            r_zero  <= (i_key == '0);
            r_phase <= 1'b0;
            // final slot for a power-of-two size and for a zero key
            r_rem   <= i_key[IDX_W-1:0];
        end else if (r_busy) begin
            r_phase <= 1'b1;
            if (!r_phase) begin
                r_quo <= KEY_W'(w_prod >> RSH);
            end else begin
                r_rem <= w_rem[IDX_W-1:0];
            end
        end
    end

endmodule

### design/k2id_back.sv
// Probe engine: clears the table, probes linearly, inserts and drives results.
module k2id_back #(
    parameter int TABLE_SIZE = 256,
    localparam int IDX_W     = $clog2(TABLE_SIZE),
    localparam int FW        = 1 + k2id_pkg::KEY_W + IDX_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    output logic                     o_enable,
    input  logic                     i_q_valid,
    input  logic [FW-1:0]            i_q_data,
    output logic                     o_q_pop,
    output logic                     o_we,
    output logic [IDX_W-1:0]         o_waddr,
    output k2id_pkg::t_slot_word     o_wdata,
    output logic [IDX_W-1:0]         o_raddr,
    input  k2id_pkg::t_slot_word     i_rdata,
    output logic                     o_valid,
    output logic [k2id_pkg::ID_W-1:0] o_small_id,
    output k2id_pkg::t_status        o_status,
    input  logic                     i_ready
);
    import k2id_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

    t_bstate          r_state, n_state;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_clr, n_clr;
    logic [ID_W-1:0]  r_next_id, n_next_id;
    logic             r_ov;
    logic [ID_W-1:0]  r_id;
    t_status          r_st;

    logic             q_zero;
    logic [KEY_W-1:0] q_key;
    logic [IDX_W-1:0] q_slot;
    logic             w_free;
    logic             w_empty;
    logic             w_match;
    logic             w_load;
    logic [ID_W-1:0]  w_id;
    t_status          w_st;
    logic [IDX_W-1:0] w_slot_inc;

    assign {q_zero, q_key, q_slot} = i_q_data;
    assign w_free     = !r_ov || i_ready;
    assign w_empty    = (i_rdata.key == '0);
    assign w_match    = (i_rdata.key == q_key);
    assign w_slot_inc = (r_slot == LAST) ? '0 : r_slot + 1'b1;
    assign o_enable   = (r_state != BS_CLEAR);

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_clr     = r_clr;
        n_next_id = r_next_id;
        o_raddr   = r_slot;
        o_we      = 1'b0;
        o_waddr   = r_slot;
        o_wdata   = '{key: q_key, id: r_next_id};
        o_q_pop   = 1'b0;
        w_load    = 1'b0;
        w_id      = '0;
        w_st      = ST_ZERO;
        unique case (r_state)
            BS_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == LAST) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_q_valid) begin
                    if (q_zero) begin
                        if (w_free) begin
                            w_load  = 1'b1;
                            o_q_pop = 1'b1;
                        end
                    end else begin
                        o_raddr = q_slot;
                        n_slot  = q_slot;
                        n_cnt   = '0;
                        n_state = BS_PROBE;
                    end
                end
            end
            BS_PROBE: begin
                // read data belongs to r_slot
                priority if (w_empty || w_match || (r_cnt == LAST)) begin
                    if (w_free) begin
                        w_load  = 1'b1;
                        o_q_pop = 1'b1;
                        n_state = BS_IDLE;
                        priority if (w_empty) begin
                            o_we      = 1'b1;
                            w_id      = r_next_id;
                            w_st      = ST_INSERTED;
                            n_next_id = r_next_id + 1'b1;
                        end else if (w_match) begin
                            w_id = i_rdata.id;
                            w_st = ST_FOUND;
                        end else begin
                            w_st = ST_FULL;
                        end
                    end
                end else begin
                    o_raddr = w_slot_inc;
                    n_slot  = w_slot_inc;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_CLEAR;
            r_clr     <= '0;
            r_next_id <= ID_W'(1);
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_next_id <= n_next_id;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_cnt  <= n_cnt;
        if (w_load) begin
            r_id <= w_id;
            r_st <= w_st;
        end
    end

    assign o_valid    = r_ov;
    assign o_small_id = r_id;
    assign o_status   = r_st;

`ifndef SYNTHESIS
    a_probe_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_PROBE) |-> (i_q_valid && !q_zero))
        else $error("probing without a nonzero job at the queue head");
    a_write_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> ((r_state == BS_CLEAR) || ((r_state == BS_PROBE) && w_empty)))
        else $error("table write outside clear or insert");
    a_id_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_st == ST_INSERTED)) |=> (r_next_id == $past(r_next_id) + 1'b1))
        else $error("id counter did not advance on insert");
    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && ((r_st == ST_ZERO) || (r_st == ST_FULL))) |-> (r_id == '0))
        else $error("zero-key or full result carries a nonzero id");
`endif

endmodule

### design/key_to_sequential_id_map_unit.sv
// Top level of the key to sequential id map: front end, queue, probe engine, table RAM.
// Order: the front end registers each key and its home slot, directly for a power-of-two
//   TABLE_SIZE, else after a reciprocal multiply then a multiply-subtract; then the queue;
//   then the probe engine reads slots in turn from the home slot, 1 to TABLE_SIZE of them,
//   through the single registered read port of the table RAM, and holds one item at a time;
//   zero keys need no read. A non-power-of-two front end takes no key while busy on a remainder.
// Reset: synchronous, active low; afterwards a clearing pass writes all TABLE_SIZE slots,
//   one per cycle, while o_ready stays low. The id counter restarts at 1.
module key_to_sequential_id_map_unit #(
    parameter int TABLE_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_key,
    output logic        o_ready,
    output logic        o_valid,
    output logic [15:0] o_small_id,
    output logic [1:0]  o_status,
    input  logic        i_ready
);
    import k2id_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int FW    = 1 + KEY_W + IDX_W;

    // front end to queue
    logic             w_push_valid;
    logic             w_push_ready;
    logic [FW-1:0]    w_push_data;
    // queue to probe engine
    logic             w_q_valid;
    logic [FW-1:0]    w_q_data;
    logic             w_q_pop;
    // probe engine to table and back, enable to front end, status
    logic             w_enable;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [IDX_W-1:0] w_raddr;
    t_slot_word       w_wdata;
    t_slot_word       w_rdata;
    t_status          w_status;

    k2id_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (w_enable),
        .i_valid      (i_valid),
        .i_key        (i_key),
        .o_ready      (o_ready),
        .o_push_valid (w_push_valid),
        .o_push_data  (w_push_data),
        .i_push_ready (w_push_ready)
    );

    k2id_fifo #(.W(FW)) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_push_valid),
        .o_wr_ready (w_push_ready),
        .i_wr_data  (w_push_data),
        .o_rd_valid (w_q_valid),
        .o_rd_data  (w_q_data),
        .i_rd_pop   (w_q_pop)
    );

    // one word per slot: key and its id side by side
    k2id_ram #(.W($bits(t_slot_word)), .DEPTH(TABLE_SIZE)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    k2id_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_enable   (w_enable),
        .i_q_valid  (w_q_valid),
        .i_q_data   (w_q_data),
        .o_q_pop    (w_q_pop),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr    (w_raddr),
        .i_rdata    (w_rdata),
        .o_valid    (o_valid),
        .o_small_id (o_small_id),
        .o_status   (w_status),
        .i_ready    (i_ready)
    );

    assign o_status = w_status;

endmodule

### tb/key_to_sequential_id_map_unit_test.sv
// Self-checking testbench for the key to sequential id map: random key traffic with a shadow table.
module key_to_sequential_id_map_unit_test;
    import k2id_pkg::*;

    // Build size under test; the shadow table below must match it.
    localparam int TABLE_SIZE = 256;
    // Cycles with no word moving on either side before the run is declared hung.
    // Slowest legit gap: clearing pass or a full-table miss, plus pipeline and a random
    // stall on the result side, taken well over.
    localparam int STALL_LIMIT = 12 * TABLE_SIZE + 500;
    // Quiet time after the last result, to catch a stray word: one full probe and margin.
    localparam int DRAIN_CYCLES = TABLE_SIZE + 50;
    localparam int N_RANDOM = 1230;

    // One expected result word.
    typedef struct packed {
        logic [ID_W-1:0] small_id;
        t_status         status;
    } t_id_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [KEY_W-1:0]  i_key = '0;
    logic              o_ready;
    logic              o_valid;
    logic [ID_W-1:0]   o_small_id;
    logic [1:0]        o_status;
    logic              i_ready = 1'b0;

    key_to_sequential_id_map_unit #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_key     (i_key),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .o_small_id(o_small_id),
        .o_status  (o_status),
        .i_ready   (i_ready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow table: keys, their ids and the id counter, as the block
    // should hold them after every accepted key.
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] shadow_keys [TABLE_SIZE];
    logic [ID_W-1:0]  shadow_ids  [TABLE_SIZE];
    logic [ID_W-1:0]  next_small_id = 16'd1;

    initial begin
        for (int s = 0; s < TABLE_SIZE; s++) begin
            shadow_keys[s] = '0;
            shadow_ids[s]  = '0;
        end
    end

    // Linear probe from key mod size, wrapping at the top. First empty slot
    // takes the key with the current counter value; a match returns its id.
    // Running through every slot with neither means the table is full.
    function automatic t_id_result lookup_key(input logic [KEY_W-1:0] key);
        t_id_result res;
        int         slot;
        res.small_id = '0;
        res.status   = ST_FULL;
        if (key == '0) begin
            res.status = ST_ZERO;
            return res;
        end
        slot = int'(key % TABLE_SIZE);
        for (int probes = 0; probes < TABLE_SIZE; probes++) begin
            if (shadow_keys[slot] == '0) begin
                res.small_id      = next_small_id;
                res.status        = ST_INSERTED;
                shadow_keys[slot] = key;
                shadow_ids[slot]  = next_small_id;
                next_small_id     = next_small_id + 16'd1;   // wraps at 16 bits
                break;
            end
            if (shadow_keys[slot] == key) begin
                res.small_id = shadow_ids[slot];
                res.status   = ST_FOUND;
                break;
            end
            slot = (slot + 1 == TABLE_SIZE) ? 0 : slot + 1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] keys_to_send [$];
    t_id_result       expected_ids [$];
    int               words_sent   = 0;
    int               errors       = 0;
    int               stall_cycles = 0;
    int               n_found = 0, n_inserted = 0, n_full = 0, n_zero = 0;
    logic             key_taken    = 1'b0;
    logic             calm;

    // A stretch in the middle of the run where neither side idles.
    assign calm = (words_sent >= 600) && (words_sent < 800);

    // ------------------------------------------------------------------
    // Key driver: falling edge. A new word goes out only when the line is
    // free or the last word was taken at the previous rising edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic send;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || key_taken) begin
            send = (keys_to_send.size() != 0) && (calm || $urandom_range(99) >= 26);
            if (send) begin
                i_key      <= keys_to_send.pop_front();
                i_valid    <= 1'b1;
                words_sent <= words_sent + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result-side back-pressure, also at the falling edge.
    always @(negedge i_clk) begin
        i_ready <= i_rst_n && (calm || $urandom_range(99) >= 26);
    end

    // ------------------------------------------------------------------
    // Monitor: rising edge. Accepted keys go through the shadow table;
    // accepted results are checked against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_id_result want;
        logic       moved;
        moved = 1'b0;
        key_taken <= i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_ids.push_back(lookup_key(i_key));
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                moved = 1'b1;
                if (expected_ids.size() == 0) begin
                    $error("result word with none expected: small_id %0d status %0d",
                           o_small_id, o_status);
                    errors++;
                end else begin
                    want = expected_ids.pop_front();
                    if (o_small_id !== want.small_id) begin
                        $error("small_id: expected %0d, got %0d", want.small_id, o_small_id);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d (%s), got %0d",
                               want.status, want.status.name(), o_status);
                        errors++;
                    end
                    case (want.status)
                        ST_FOUND:    n_found++;
                        ST_INSERTED: n_inserted++;
                        ST_FULL:     n_full++;
                        default:     n_zero++;
                    endcase
                end
            end
        end
        // The clearing pass after reset counts against the limit too.
        stall_cycles <= moved ? 0 : stall_cycles + 1;
    end

    // Hang detector.
    always @(posedge i_clk) begin
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles", STALL_LIMIT);
            $display("key_to_sequential_id_map_unit_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [KEY_W-1:0] issued [$];
        logic [KEY_W-1:0] k;
        int               pick;

        // Directed part: zero key, extremes, a collision chain that wraps from
        // the top slot back to slot 0, then hits on those keys (one after wrap).
        keys_to_send = '{
            32'h0000_0000,                  // zero key
            32'hFFFF_FFFF,                  // top slot
            32'h0000_01FF,                  // same slot, wraps to slot 0
            32'h0000_0100,                  // slot 0 taken, moves on
            32'h8000_0000,                  // longer chain from slot 0
            32'h0000_0001,                  // home slot already taken by the chain
            32'hFFFF_FFFF,                  // found at home
            32'h0000_01FF,                  // found after wrap
            32'h8000_0000,                  // found deep in the chain
            32'hAAAA_AAAA,
            32'h5555_5555,
            32'h0000_0000,
            32'h0000_0001,
            32'hAAAA_AAAA,
            32'h7FFF_FFFF,
            32'hFFFF_FF00                   // collides with slot 0 chain again
        };
        issued = keys_to_send;

        // Random part: reuse of earlier keys (hits), new keys (inserts, and table
        // full once all slots are taken), forced home-slot collisions and zeros.
        // The counter cannot wrap here: at most TABLE_SIZE keys ever go in.
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(99);
            if (pick < 7) begin
                k = '0;
            end else if (pick < 52) begin
                k = issued[$urandom_range(issued.size() - 1)];
            end else if (pick < 67) begin
                k = issued[$urandom_range(issued.size() - 1)];
                k = {24'($urandom()), k[7:0]} ^ {24'($urandom_range(1, 255)), 8'h00};
                if (k == '0) k = 32'h0000_0100;
            end else begin
                k = $urandom();
            end
            keys_to_send.push_back(k);
            if (k != '0) issued.push_back(k);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (keys_to_send.size() != 0 || i_valid || expected_ids.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_ids.size() != 0) begin
            $error("%0d results never arrived", expected_ids.size());
            errors++;
        end
        $display("covered %0d keys: %0d found, %0d inserted, %0d table full, %0d zero",
                 words_sent, n_found, n_inserted, n_full, n_zero);
        $display("table filled to %0d ids, %0d mismatches", next_small_id - 16'd1, errors);
        if (errors == 0) begin
            $display("key_to_sequential_id_map_unit_test: PASS");
        end else begin
            $display("key_to_sequential_id_map_unit_test: FAIL");
        end
        $finish;
    end

endmodule

### key_to_sequential_id_map_unit.f
design/k2id_pkg.sv
design/k2id_ram.sv
design/k2id_fifo.sv
design/k2id_front.sv
design/k2id_back.sv
design/key_to_sequential_id_map_unit.sv
tb/key_to_sequential_id_map_unit_test.sv
